FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/twfs_pkg.sv
`timescale 1ns / 1ps
package twfs_pkg;

  localparam int RING_DEPTH = 512;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int STAMP_W    = 64;
  localparam int US_W       = 20;
  localparam logic [US_W-1:0] US_PER_SECOND = 20'd1000000;
  localparam int PROD_W     = STAMP_W + US_W;
  localparam int DIVISOR_W  = 32;
  localparam int STEP_W     = $clog2(PROD_W + 1);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_US        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_FREQUENCY = 4'd1;
  localparam logic [31:0] WINDOW_US_RESET         = 32'd1000000;
  localparam logic [31:0] COUNTER_FREQUENCY_RESET = 32'd1000000;

  localparam int COUNT_OUT_W = 10;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 112;
  localparam int OUT_USER_W  = 1;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_PUSH,
    S_DROP_RD,
    S_DROP_SUB,
    S_TRIM,
    S_STATS,
    S_AVG,
    S_SCAN_START,
    S_SCAN,
    S_DONE
  } seq_state_t;

  // Ring position of a sum that stays below twice the depth.
  function automatic logic [RING_AW-1:0] ring_wrap(input logic [CNT_W:0] s);
    logic [CNT_W:0] t;
    t = (s >= (CNT_W+1)'(RING_DEPTH)) ? s - (CNT_W+1)'(RING_DEPTH) : s;
    return t[RING_AW-1:0];
  endfunction

endpackage

FILE: rtl/twfs_ram.sv
`timescale 1ns / 1ps
module twfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/twfs_muldiv.sv
`timescale 1ns / 1ps
module twfs_muldiv (
  input  logic                           clk,
  input  logic                           rst,
  input  twfs_pkg::unit_req_t            req,
  output twfs_pkg::unit_stat_t           stat,
  input  logic [twfs_pkg::PROD_W-1:0]    opnd_a,
  input  logic [twfs_pkg::DIVISOR_W-1:0] opnd_b,
  output logic [twfs_pkg::PROD_W-1:0]    result
);
  import twfs_pkg::*;

  logic                 busy;
  logic                 done;
  unit_op_t             op;
  logic [STEP_W-1:0]    steps;
  logic [PROD_W-1:0]    work;
  logic [STAMP_W-1:0]   mcand;
  logic [US_W-1:0]      mul_k;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W-1:0] rem;

  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;
  logic [PROD_W-1:0]    mul_next;

  always_comb begin
    rem_sh   = {rem, work[PROD_W-1]};
    diff     = rem_sh - {1'b0, divisor};
    fits     = rem_sh >= {1'b0, divisor};
    mul_next = {work[PROD_W-2:0], 1'b0} + (mul_k[US_W-1] ? PROD_W'(mcand) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
      op    <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy  <= 1'b1;
        op    <= req.op;
        steps <= (req.op == OP_MUL) ? STEP_W'(US_W) : STEP_W'(PROD_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (op == OP_MUL) begin
        work  <= mul_next;
        mul_k <= {mul_k[US_W-2:0], 1'b0};
      end else begin
        // Restoring division, one quotient bit per cycle.
        rem  <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        work <= {work[PROD_W-2:0], fits};
      end
    end else if (req.start) begin
      mcand   <= opnd_a[STAMP_W-1:0];
      mul_k   <= US_PER_SECOND;
      divisor <= opnd_b;
      rem     <= '0;
      work    <= (req.op == OP_MUL) ? '0 : opnd_a;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = work;

endmodule

FILE: rtl/time_window_frame_statistics_unit.sv
`timescale 1ns / 1ps
// Frame time statistics over a sliding time window. Each item on s_tdata is a
// 64-bit counter timestamp; each one yields exactly one result item on the
// master side. The first timestamp after reset is only remembered and reports
// the empty window. Later ones compute min(floor(delta * 1000000 / frequency),
// 0xFFFFFFFF) on one shared iterative multiply/divide unit (first the scaling
// multiply, then the divide), push the time into a 512-entry ring RAM, trim
// the window (each dropped sample reads the RAM, is subtracted and then the
// window is rechecked), divide the sum by the count and scan the retained
// samples for min and max at one RAM read per cycle. The next item is taken
// only once the current one has finished; s_tready is high only while the
// block is idle.
// A finished result waits in the output register; the next item may be taken
// meanwhile. The ring needs no clearing pass after reset. Configuration writes
// are accepted every cycle and should be made only while the block is idle.
`include "assert_macros.svh"
module time_window_frame_statistics_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [twfs_pkg::IN_DATA_W-1:0]  s_tdata,   // [63:0] timestamp
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] average_us, [63:32] minimum_us, [95:64] maximum_us,
  // [105:96] retained_count, [111:106] zero
  output logic [twfs_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [twfs_pkg::OUT_USER_W-1:0] m_tuser,   // [0] sample_taken
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [twfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import twfs_pkg::*;

  seq_state_t           state;
  seq_state_t           state_next;

  logic [31:0]          window_us;
  logic [31:0]          counter_frequency;
  logic                 have_previous;
  logic [STAMP_W-1:0]   previous_stamp;
  logic [RING_AW-1:0]   oldest_slot;
  logic [CNT_W-1:0]     held_count;
  logic [SUM_W-1:0]     window_sum;
  logic [SAMPLE_W-1:0]  elapsed;
  logic                 taken;
  logic                 drop_for_push;
  logic                 scan_first;
  logic [RING_AW-1:0]   scan_ptr;
  logic [CNT_W-1:0]     scan_left;
  logic [SAMPLE_W-1:0]  avg_r;
  logic [SAMPLE_W-1:0]  lo_r;
  logic [SAMPLE_W-1:0]  hi_r;

  logic                 in_accept;
  logic                 ring_full;
  logic                 ram_we;
  logic [RING_AW-1:0]   ram_waddr;
  logic [RING_AW-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0]  ram_rdata;

  unit_req_t            unit_req;
  unit_stat_t           unit_stat;
  logic [PROD_W-1:0]    unit_a;
  logic [DIVISOR_W-1:0] unit_b;
  logic [PROD_W-1:0]    unit_result;
  logic [SAMPLE_W-1:0]  quot_sat;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign ring_full = held_count >= CNT_W'(RING_DEPTH);
  assign quot_sat  = (|unit_result[PROD_W-1:SAMPLE_W]) ? '1 : unit_result[SAMPLE_W-1:0];

  twfs_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(elapsed),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  twfs_muldiv u_unit (
    .clk   (clk),
    .rst   (rst),
    .req   (unit_req),
    .stat  (unit_stat),
    .opnd_a(unit_a),
    .opnd_b(unit_b),
    .result(unit_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    unit_req.start = 1'b0;
    unit_req.op    = OP_MUL;
    unit_a         = PROD_W'(s_tdata - previous_stamp);
    unit_b         = counter_frequency;
    ram_we         = 1'b0;
    ram_waddr      = ring_wrap((CNT_W+1)'(oldest_slot) + (CNT_W+1)'(held_count));
    ram_raddr      = oldest_slot;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (have_previous) begin
            unit_req.start = 1'b1;
            state_next     = S_MUL;
          end else begin
            state_next = S_STATS;
          end
        end
      end
      S_MUL: begin
        unit_a = unit_result;
        if (unit_stat.done) begin
          unit_req.start = 1'b1;
          unit_req.op    = OP_DIV;
          state_next     = S_DIV;
        end
      end
      S_DIV: begin
        if (unit_stat.done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (ring_full) begin
          state_next = S_DROP_RD;
        end else begin
          ram_we     = 1'b1;
          state_next = S_TRIM;
        end
      end
      S_DROP_RD: begin
        state_next = S_DROP_SUB;
      end
      S_DROP_SUB: begin
        state_next = drop_for_push ? S_PUSH : S_TRIM;
      end
      S_TRIM: begin
        if (held_count > CNT_W'(1) && window_sum > SUM_W'(window_us)) begin
          state_next = S_DROP_RD;
        end else begin
          state_next = S_STATS;
        end
      end
      S_STATS: begin
        unit_a = PROD_W'(window_sum);
        unit_b = DIVISOR_W'(held_count);
        if (held_count == '0) begin
          state_next = S_DONE;
        end else begin
          unit_req.start = 1'b1;
          unit_req.op    = OP_DIV;
          state_next     = S_AVG;
        end
      end
      S_AVG: begin
        if (unit_stat.done) begin
          state_next = S_SCAN_START;
        end
      end
      S_SCAN_START: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ram_raddr = scan_ptr;
        if (scan_left == CNT_W'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_us         <= WINDOW_US_RESET;
      counter_frequency <= COUNTER_FREQUENCY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_US:         window_us         <= cfg_data;
        REG_COUNTER_FREQUENCY: counter_frequency <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window state and sequencer control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous  <= 1'b0;
      previous_stamp <= '0;
      oldest_slot    <= '0;
      held_count     <= '0;
      window_sum     <= '0;
      taken          <= 1'b0;
      drop_for_push  <= 1'b0;
      scan_first     <= 1'b0;
      scan_left      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            have_previous  <= 1'b1;
            previous_stamp <= s_tdata;
            taken          <= have_previous;
          end
        end
        S_PUSH: begin
          if (ring_full) begin
            drop_for_push <= 1'b1;
          end else begin
            window_sum <= window_sum + SUM_W'(elapsed);
            held_count <= held_count + 1'b1;
          end
        end
        S_DROP_SUB: begin
          window_sum  <= window_sum - SUM_W'(ram_rdata);
          oldest_slot <= ring_wrap((CNT_W+1)'(oldest_slot) + (CNT_W+1)'(1));
          held_count  <= held_count - 1'b1;
        end
        S_TRIM: begin
          drop_for_push <= 1'b0;
        end
        S_SCAN_START: begin
          scan_first <= 1'b1;
          scan_left  <= held_count;
        end
        S_SCAN: begin
          scan_first <= 1'b0;
          scan_left  <= scan_left - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      S_DIV: begin
        if (unit_stat.done) begin
          elapsed <= quot_sat;
        end
      end
      S_STATS: begin
        if (held_count == '0) begin
          avg_r <= '0;
          lo_r  <= '0;
          hi_r  <= '0;
        end
      end
      S_AVG: begin
        if (unit_stat.done) begin
          avg_r <= unit_result[SAMPLE_W-1:0];
        end
      end
      S_SCAN_START: begin
        scan_ptr <= ring_wrap((CNT_W+1)'(oldest_slot) + (CNT_W+1)'(1));
      end
      S_SCAN: begin
        // Data read last cycle arrives now; advance the read pointer.
        scan_ptr <= ring_wrap((CNT_W+1)'(scan_ptr) + (CNT_W+1)'(1));
        if (scan_first || ram_rdata < lo_r) begin
          lo_r <= ram_rdata;
        end
        if (scan_first || ram_rdata > hi_r) begin
          hi_r <= ram_rdata;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tuser <= OUT_USER_W'(taken);
      m_tdata <= OUT_DATA_W'({COUNT_OUT_W'(held_count), hi_r, lo_r, avg_r});
    end
  end

  `ASSERT_ALWAYS(a_count_bound, held_count <= CNT_W'(RING_DEPTH), "ring count over depth")
  `ASSERT_ALWAYS(a_trim_done,
    !(state == S_STATS && held_count > CNT_W'(1)) || window_sum <= SUM_W'(window_us),
    "window not trimmed before statistics")
  `ASSERT_NEXT(a_start_scale, in_accept && have_previous,
    state == S_MUL && unit_stat.busy, "scaling did not start on a timestamp item")
  `ASSERT_ALWAYS(a_avg_in_range, state != S_DONE || (lo_r <= avg_r && avg_r <= hi_r),
    "average outside min/max")

endmodule

FILE: tb/sv/time_window_frame_statistics_unit_tb.sv
`timescale 1ns / 1ps
module time_window_frame_statistics_unit_tb;
  import twfs_pkg::*;

  localparam int RUN_CYCLE_LIMIT = 6000000;
  localparam int RANDOM_ITEMS    = 290;
  localparam int RING_FILL_ITEMS = 530;
  localparam int SETTLE_CYCLES   = 2000;

  typedef struct packed {
    logic        sample_taken;
    logic [31:0] average_us;
    logic [31:0] minimum_us;
    logic [31:0] maximum_us;
    logic [9:0]  retained_count;
  } frame_stats_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;    // [63:0] timestamp
  logic                  m_tvalid;
  logic                  m_tready;
  // [31:0] average_us, [63:32] minimum_us, [95:64] maximum_us, [105:96] retained_count
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;    // [0] sample_taken
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  time_window_frame_statistics_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state
  logic [31:0]  frame_times [RING_DEPTH];
  int unsigned  first_slot = 0;
  int unsigned  span_count = 0;
  logic [63:0]  span_sum = '0;
  logic [63:0]  last_stamp = '0;
  logic         stamp_seen = 1'b0;
  logic [31:0]  cur_window = WINDOW_US_RESET;
  logic [31:0]  cur_frequency = COUNTER_FREQUENCY_RESET;

  frame_stats_t stats_due [$];
  int           fault_count = 0;

  // Stimulus control
  logic [63:0]  stamp_now = '0;
  bit           sender_no_gaps = 1'b0;
  bit           sink_no_stalls = 1'b0;
  int           stall_left = 0;
  int           sink_hold = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (RUN_CYCLE_LIMIT) @(posedge clk);
    $display("time_window_frame_statistics_unit_tb: errors");
    $finish;
  end

  function automatic logic [31:0] stamp_gap_us(input logic [63:0] delta,
                                               input logic [31:0] freq);
    logic [95:0] scaled;
    logic [95:0] quot;
    if (freq == '0) return 32'hFFFF_FFFF;
    scaled = 96'(delta) * 96'(US_PER_SECOND);
    quot   = scaled / 96'(freq);
    return (quot > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
  endfunction

  function automatic void drop_oldest_time();
    span_sum   = span_sum - 64'(frame_times[first_slot]);
    first_slot = (first_slot + 1) % RING_DEPTH;
    span_count = span_count - 1;
  endfunction

  function automatic frame_stats_t frame_stats_after(input logic [63:0] stamp);
    frame_stats_t r;
    logic [31:0]  t;
    logic [31:0]  s;
    int unsigned  i;
    r = '0;
    if (!stamp_seen) begin
      stamp_seen = 1'b1;
      last_stamp = stamp;
    end else begin
      t = stamp_gap_us(stamp - last_stamp, cur_frequency);
      last_stamp = stamp;
      if (span_count >= RING_DEPTH) drop_oldest_time();
      frame_times[(first_slot + span_count) % RING_DEPTH] = t;
      span_sum   = span_sum + 64'(t);
      span_count = span_count + 1;
      while (span_count > 1 && span_sum > 64'(cur_window)) drop_oldest_time();
      r.sample_taken = 1'b1;
    end
    if (span_count > 0) begin
      r.average_us = 32'(span_sum / 64'(span_count));
      r.minimum_us = frame_times[first_slot];
      r.maximum_us = frame_times[first_slot];
      for (i = 1; i < span_count; i++) begin
        s = frame_times[(first_slot + i) % RING_DEPTH];
        if (s < r.minimum_us) r.minimum_us = s;
        if (s > r.maximum_us) r.maximum_us = s;
      end
    end
    r.retained_count = 10'(span_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  // Check results first, then predict for the item taken at the same edge
  always @(posedge clk) begin
    frame_stats_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (stats_due.size() == 0) begin
          $error("result item with no timestamp pending");
          fault_count++;
        end else begin
          want = stats_due.pop_front();
          check_field("sample_taken", 32'(want.sample_taken), 32'(m_tuser[0]));
          check_field("average_us", want.average_us, m_tdata[31:0]);
          check_field("minimum_us", want.minimum_us, m_tdata[63:32]);
          check_field("maximum_us", want.maximum_us, m_tdata[95:64]);
          check_field("retained_count", 32'(want.retained_count), 32'(m_tdata[105:96]));
        end
        stall_left = sink_no_stalls ? 0 : $urandom_range(19, 0);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_US) cur_window = cfg_data;
        else if (cfg_index == REG_COUNTER_FREQUENCY) cur_frequency = cfg_data;
      end
      if (s_tvalid && s_tready) stats_due.push_back(frame_stats_after(s_tdata));
    end
  end

  // Result side: long hold-off first, then per-item stalls
  initial begin
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_stamp(input logic [63:0] ts);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(19, 0);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid  <= 1'b1;
    s_tdata   <= ts;
    stamp_now = ts;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_after(input logic [63:0] delta);
    send_stamp(stamp_now + delta);
  endtask

  // Drop valid and wait for every pending result
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_first_stamp_and_wrap();
    send_stamp(64'd0);
    send_stamp(64'd16667);
    send_stamp(64'd33334);
    send_stamp(64'd50000);
    send_stamp(64'd0);                    // counter going backward
    send_stamp(64'd0);                    // zero stamp, zero gap
    send_stamp(64'hFFFF_FFFF_FFFF_FFFF);
    send_stamp(64'd0);                    // forward across the wrap
    drain();
  endtask

  task automatic test_saturation_limits();
    write_reg(REG_COUNTER_FREQUENCY, 32'd1);
    write_reg(REG_WINDOW_US, 32'hFFFF_FFFF);
    send_after(64'd4294);
    send_after(64'd4295);
    drain();
    write_reg(REG_COUNTER_FREQUENCY, COUNTER_FREQUENCY_RESET);
    send_after(64'd4294967295);           // exactly the largest time
    send_after(64'd4294967296);
    drain();
    write_reg(REG_COUNTER_FREQUENCY, 32'hFFFF_FFFF);
    send_after(64'hFFFF_FFFF);
    send_after(64'hFFFF_FFFF_FFFF_FFFF);
    drain();
  endtask

  task automatic test_zero_window_and_frequency();
    write_reg(REG_COUNTER_FREQUENCY, 32'd0);
    send_after(64'd5);
    drain();
    write_reg(REG_COUNTER_FREQUENCY, COUNTER_FREQUENCY_RESET);
    write_reg(REG_WINDOW_US, 32'd0);
    send_after(64'd100);
    send_after(64'd7);
    send_after(64'd0);
    drain();
  endtask

  task automatic test_spare_register_index();
    int i;
    write_reg(REG_WINDOW_US, 32'd50000);
    for (i = int'(REG_COUNTER_FREQUENCY) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), $urandom);
    send_after(64'd20000);
    send_after(64'd40000);
    drain();
  endtask

  task automatic test_ring_wraparound();
    int i;
    write_reg(REG_WINDOW_US, 32'hFFFF_FFFF);
    write_reg(REG_COUNTER_FREQUENCY, COUNTER_FREQUENCY_RESET);
    for (i = 0; i < RING_FILL_ITEMS; i++) begin
      sender_no_gaps = (i % 100) < 30;
      send_after(64'($urandom_range(1000, 0)));
    end
    sender_no_gaps = 1'b0;
    drain();
    // trim a full ring down to one sample
    write_reg(REG_WINDOW_US, 32'd0);
    send_after(64'd3);
    drain();
  endtask

  task automatic test_output_backpressure();
    int i;
    write_reg(REG_WINDOW_US, 32'd100000);
    sender_no_gaps = 1'b1;
    sink_hold = 3000;
    for (i = 0; i < 8; i++) send_after(64'($urandom_range(20000, 1000)));
    sender_no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_random_frames();
    int          sent;
    int          n;
    int          k;
    logic [31:0] win;
    logic [31:0] freq;
    logic [63:0] span;
    logic [63:0] near_top;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(5, 0))
        0: win = 32'd0;
        1: win = 32'd1;
        2: win = 32'hFFFF_FFFF;
        3: win = $urandom;
        default: win = $urandom_range(2000000, 1000);
      endcase
      case ($urandom_range(6, 0))
        0: freq = 32'd0;
        1: freq = 32'd1;
        2: freq = 32'hFFFF_FFFF;
        3: freq = COUNTER_FREQUENCY_RESET;
        4: freq = $urandom;
        default: freq = $urandom_range(100000000, 1000);
      endcase
      write_reg(REG_WINDOW_US, win);
      write_reg(REG_COUNTER_FREQUENCY, freq);
      k = $urandom_range(64, 1);
      span = (64'(win) * 64'(freq)) / (64'd1000000 * 64'(k)) + 64'd1;
      near_top = (64'(freq) * 64'hFFFF_FFFF) / 64'd1000000;
      sender_no_gaps = ($urandom_range(3, 0) == 0);
      sink_no_stalls = ($urandom_range(3, 0) == 0);
      n = $urandom_range(40, 15);
      repeat (n) begin
        case ($urandom_range(9, 0))
          0: send_stamp({$urandom, $urandom});
          1: send_stamp(stamp_now - 64'($urandom_range(1000, 1)));
          2: send_after(near_top + 64'($urandom_range(2, 0)) - 64'd1);
          default: send_after({$urandom, $urandom} % (64'd2 * span + 64'd1));
        endcase
        sent++;
      end
      drain();
    end
    sender_no_gaps = 1'b0;
    sink_no_stalls = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_stamp_and_wrap();
    test_saturation_limits();
    test_zero_window_and_frequency();
    test_spare_register_index();
    test_ring_wraparound();
    test_output_backpressure();
    test_random_frames();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && stats_due.size() == 0)
      $display("time_window_frame_statistics_unit_tb: clean");
    else
      $display("time_window_frame_statistics_unit_tb: errors");
    $finish;
  end

endmodule
